FILE: hw/rtl/hex_debug_command_breakpoint_unit_top_defines.svh
// Assertion helpers used by the back end RTL file of the breakpoint unit.
`ifndef HEX_DEBUG_COMMAND_BREAKPOINT_UNIT_TOP_DEFINES_SVH
`define HEX_DEBUG_COMMAND_BREAKPOINT_UNIT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define HDCB_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define HDCB_ASSERT(lbl, prop, msg) \
  `HDCB_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define HDCB_ASSERT_CLK(lbl, ck, rs, prop, msg)
`define HDCB_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/hdcb_pkg.sv
package hdcb_pkg;

  // command codes (first byte of a message)
  localparam logic [7:0] CMD_RUN         = 8'h01;
  localparam logic [7:0] CMD_HALT        = 8'h02;
  localparam logic [7:0] CMD_PAUSE       = 8'h03;
  localparam logic [7:0] CMD_STEP        = 8'h04;
  localparam logic [7:0] CMD_BP_ADD      = 8'h06;
  localparam logic [7:0] CMD_BP_REMOVE   = 8'h07;
  localparam logic [7:0] CMD_DUMP        = 8'h10;
  localparam logic [7:0] CMD_DUMP_LOCALS = 8'h11;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_PAUSE = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_HALT  = 2'd3;

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;
  localparam logic [3:0] BYTES_MAX      = 4'd15;

  // what the back end has to do with a queued item
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_DROP = 2'd1,
    KIND_EXEC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] cmd;
  } q_ctrl_t;

  // packed MSB first, so command_done lands in bit 0
  typedef struct packed {
    logic        unknown_command;
    logic        table_full;
    logic        message_dropped;
    logic        skip_valid;
    logic [31:0] skip_address;
    logic        hit;
    logic [1:0]  run_mode;
    logic [7:0]  command_code;
    logic        command_done;
  } result_t;

endpackage

FILE: hw/rtl/hdcb_fifo.sv
module hdcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/hdcb_front.sv
module hdcb_front import hdcb_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 action,
  input  logic [7:0]           char_code,
  input  logic [31:0]          pc_address,
  output logic                 q_push,
  output q_ctrl_t              q_ctrl,
  output logic [ADDR_BITS-1:0] q_addr,
  output logic [ADDR_BITS-1:0] q_pc
);

  logic                 half_pending;
  logic [3:0]           high_nibble;
  logic [3:0]           bytes_in_msg;
  logic [7:0]           command_byte;
  logic [7:0]           length_byte;
  logic [ADDR_BITS-1:0] addr_acc;
  logic                 halted;

  logic                 half_pending_next;
  logic [3:0]           high_nibble_next;
  logic [3:0]           bytes_in_msg_next;
  logic [7:0]           command_byte_next;
  logic [7:0]           length_byte_next;
  logic [ADDR_BITS-1:0] addr_acc_next;

  logic                 is_digit;
  logic [3:0]           digit;
  logic                 live;
  logic [7:0]           byte_val;
  logic [5:0]           shamt;
  kind_t                kind;

  always_comb begin
    is_digit = 1'b1;
    digit    = char_code[3:0];
    if (char_code inside {[CHAR_0:CHAR_9]}) begin
      digit = char_code[3:0];
    end else if (char_code inside {[CHAR_A:CHAR_F]}) begin
      digit = char_code[3:0] - 4'd1 + HEX_ALPHA_BASE;
    end else begin
      is_digit = 1'b0;
    end
  end

  assign live     = !action && !halted;
  assign byte_val = {high_nibble, digit};
  assign shamt    = {length_byte[2:0], 3'b000};

  // remaining expected bytes count as zeros; eight or more clears the address
  assign q_addr = (|length_byte[7:3]) ? '0 : (addr_acc << shamt);
  assign q_pc   = ADDR_BITS'(pc_address);
  assign q_push = accept;

  always_comb begin
    kind = KIND_PASS;
    if (live && !is_digit) begin
      if (half_pending) begin
        kind = KIND_DROP;
      end else if (bytes_in_msg != '0) begin
        kind = KIND_EXEC;
      end
    end
  end

  assign q_ctrl.kind = kind;
  assign q_ctrl.cmd  = command_byte;

  always_comb begin
    half_pending_next = half_pending;
    high_nibble_next  = high_nibble;
    bytes_in_msg_next = bytes_in_msg;
    command_byte_next = command_byte;
    length_byte_next  = length_byte;
    addr_acc_next     = addr_acc;
    if (live) begin
      if (!is_digit) begin
        if (half_pending || (bytes_in_msg != '0)) begin
          half_pending_next = 1'b0;
          bytes_in_msg_next = '0;
          command_byte_next = '0;
          length_byte_next  = '0;
          addr_acc_next     = '0;
        end
      end else if (!half_pending) begin
        high_nibble_next  = digit;
        half_pending_next = 1'b1;
      end else begin
        half_pending_next = 1'b0;
        if (bytes_in_msg == 4'd0) begin
          command_byte_next = byte_val;
          length_byte_next  = '0;
          addr_acc_next     = '0;
        end else if (bytes_in_msg == 4'd1) begin
          length_byte_next = byte_val;
        end else if (length_byte != '0) begin
          addr_acc_next    = ADDR_BITS'({addr_acc, byte_val});
          length_byte_next = length_byte - 1'b1;
        end
        if (bytes_in_msg != BYTES_MAX) begin
          bytes_in_msg_next = bytes_in_msg + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_pending <= 1'b0;
      high_nibble  <= '0;
      bytes_in_msg <= '0;
      command_byte <= '0;
      length_byte  <= '0;
      addr_acc     <= '0;
      halted       <= 1'b0;
    end else if (accept) begin
      half_pending <= half_pending_next;
      high_nibble  <= high_nibble_next;
      bytes_in_msg <= bytes_in_msg_next;
      command_byte <= command_byte_next;
      length_byte  <= length_byte_next;
      addr_acc     <= addr_acc_next;
      // halt is unconditional, so the front knows it as soon as it is queued
      if (kind == KIND_EXEC && command_byte == CMD_HALT) begin
        halted <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/hdcb_back.sv
`include "hex_debug_command_breakpoint_unit_top_defines.svh"

module hdcb_back import hdcb_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  q_ctrl_t              q_ctrl,
  input  logic [ADDR_BITS-1:0] q_addr,
  input  logic [ADDR_BITS-1:0] q_pc,
  output logic                 q_pop,
  output result_t              res,
  output logic                 res_valid,
  input  logic                 res_ready
);

  typedef enum logic [1:0] {
    BS_IDLE = 2'b01,
    BS_EXEC = 2'b10
  } bstate_t;

  bstate_t                state;
  q_ctrl_t                cur_ctrl;
  logic [ADDR_BITS-1:0]   cur_addr;
  logic [ADDR_BITS-1:0]   cur_pc;
  logic [TABLE_DEPTH-1:0] match_a;
  logic [TABLE_DEPTH-1:0] match_p;
  logic [TABLE_DEPTH-1:0] valid;
  logic [ADDR_BITS-1:0]   entry_addr [TABLE_DEPTH];
  logic [1:0]             mode;
  logic [ADDR_BITS-1:0]   skip_reg;
  logic                   skip_set;

  logic [TABLE_DEPTH-1:0] cmp_a;
  logic [TABLE_DEPTH-1:0] cmp_p;
  logic [TABLE_DEPTH-1:0] free;
  logic [TABLE_DEPTH-1:0] lowest_free;
  logic                   hit_p;
  logic                   hit_a;
  logic                   commit;

  logic [TABLE_DEPTH-1:0] valid_next;
  logic [TABLE_DEPTH-1:0] write_oh;
  logic [1:0]             mode_next;
  logic [ADDR_BITS-1:0]   skip_reg_next;
  logic                   skip_set_next;
  logic                   hit_final;
  logic                   full;
  logic                   unknown;
  result_t                res_next;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cmp_a[i] = valid[i] && (entry_addr[i] == q_addr);
      cmp_p[i] = valid[i] && (entry_addr[i] == q_pc);
    end
  end

  assign q_pop       = (state == BS_IDLE) && q_valid;
  assign commit      = (state == BS_EXEC) && (!res_valid || res_ready);
  assign free        = ~valid;
  assign lowest_free = free & (~free + TABLE_DEPTH'(1));
  assign hit_p       = |match_p;
  assign hit_a       = |match_a;

  always_comb begin
    valid_next    = valid;
    write_oh      = '0;
    mode_next     = mode;
    skip_reg_next = skip_reg;
    skip_set_next = skip_set;
    hit_final     = hit_p;
    full          = 1'b0;
    unknown       = 1'b0;
    if (cur_ctrl.kind == KIND_EXEC) begin
      case (cur_ctrl.cmd)
        CMD_RUN: begin
          if (mode == MODE_PAUSE && hit_p) begin
            skip_reg_next = cur_pc;
            skip_set_next = 1'b1;
          end
          mode_next = MODE_RUN;
        end
        CMD_HALT:  mode_next = MODE_HALT;
        CMD_PAUSE: mode_next = MODE_PAUSE;
        CMD_STEP:  mode_next = MODE_STEP;
        CMD_BP_ADD: begin
          if (!hit_a) begin
            if (|free) begin
              write_oh   = lowest_free;
              valid_next = valid | lowest_free;
              hit_final  = hit_p || (cur_addr == cur_pc);
            end else begin
              full = 1'b1;
            end
          end
        end
        CMD_BP_REMOVE: begin
          valid_next = valid & ~match_a;
          hit_final  = |(match_p & ~match_a);
        end
        CMD_DUMP, CMD_DUMP_LOCALS: mode_next = MODE_PAUSE;
        default: unknown = 1'b1;
      endcase
    end
  end

  always_comb begin
    res_next.command_done    = (cur_ctrl.kind == KIND_EXEC);
    res_next.command_code    = (cur_ctrl.kind == KIND_EXEC) ? cur_ctrl.cmd : 8'd0;
    res_next.run_mode        = mode_next;
    res_next.hit             = hit_final;
    res_next.skip_address    = 32'(skip_reg_next);
    res_next.skip_valid      = skip_set_next;
    res_next.message_dropped = (cur_ctrl.kind == KIND_DROP);
    res_next.table_full      = full;
    res_next.unknown_command = unknown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      valid     <= '0;
      mode      <= MODE_RUN;
      skip_reg  <= '0;
      skip_set  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        BS_IDLE: begin
          if (q_valid) begin
            state <= BS_EXEC;
          end
        end
        BS_EXEC: begin
          if (commit) begin
            state <= BS_IDLE;
          end
        end
        default: state <= BS_IDLE;
      endcase
      if (commit) begin
        valid     <= valid_next;
        mode      <= mode_next;
        skip_reg  <= skip_reg_next;
        skip_set  <= skip_set_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // item fields, match vectors, result and table payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctrl <= q_ctrl;
      cur_addr <= q_addr;
      cur_pc   <= q_pc;
      match_a  <= cmp_a;
      match_p  <= cmp_p;
    end
    if (commit) begin
      res <= res_next;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (commit && write_oh[i]) begin
        entry_addr[i] <= cur_addr;
      end
    end
  end

  `HDCB_ASSERT(a_commit_to_idle, (commit) |=> (state == BS_IDLE), "commit did not return to idle")
  `HDCB_ASSERT(a_halt_sticky, (mode == MODE_HALT) |=> (mode == MODE_HALT), "left halted mode")
  `HDCB_ASSERT(a_table_at_commit, (!commit) |=> $stable(valid), "table changed outside commit")

endmodule

FILE: hw/rtl/hex_debug_command_breakpoint_unit_top.sv
// An accepted transfer is queued and then executed by the back end, whose result is
// registered on m_tdata (m_tvalid high); it takes a new item only once the last commits,
// after match-then-execute on the table; a 4-entry queue decouples the character parser.
// Reset (rst, synchronous, active high): message parser cleared, mode run, table
// emptied through its valid bits at once, skip cleared, queue and output emptied.
module hex_debug_command_breakpoint_unit_top import hdcb_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // char_code[7:0], pc_address[39:8]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // command_done[0], command_code[8:1], run_mode[10:9],
                                 // hit[11], skip_address[43:12], skip_valid[44],
                                 // message_dropped[45], table_full[46], unknown_command[47]
);

  localparam int QW          = $bits(q_ctrl_t) + 2 * ADDR_BITS;
  localparam int QUEUE_DEPTH = 4;

  logic                 accept;
  logic                 q_push;
  q_ctrl_t              f_ctrl;
  logic [ADDR_BITS-1:0] f_addr;
  logic [ADDR_BITS-1:0] f_pc;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  logic [QW-1:0]        q_head;
  q_ctrl_t              b_ctrl;
  logic [ADDR_BITS-1:0] b_addr;
  logic [ADDR_BITS-1:0] b_pc;
  result_t              res;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  hdcb_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (s_tuser),
    .char_code  (s_tdata[7:0]),
    .pc_address (s_tdata[39:8]),
    .q_push     (q_push),
    .q_ctrl     (f_ctrl),
    .q_addr     (f_addr),
    .q_pc       (f_pc)
  );

  hdcb_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_pc, f_addr, f_ctrl}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .not_empty (q_valid)
  );

  assign {b_pc, b_addr, b_ctrl} = q_head;

  hdcb_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ctrl    (b_ctrl),
    .q_addr    (b_addr),
    .q_pc      (b_pc),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = res;

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import hdcb_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int POOL_SIZE    = 24;
  localparam int BP_ENTRIES   = 16;
  localparam int LINK_ITEMS   = 1500;
  // codes with no command behind them
  localparam logic [7:0] CODE_SPARE_A = 8'h20;
  localparam logic [7:0] CODE_SPARE_B = 8'h21;
  localparam logic [7:0] CODE_ZERO    = 8'h00;
  localparam logic [7:0] CODE_ALL     = 8'hFF;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic        action;
    logic [7:0]  ch;
    logic [31:0] pc;
  } link_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // char_code[7:0], pc_address[39:8]
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // result_t, command_done in bit 0

  link_item_t link_q[$];
  link_item_t cur;
  result_t    response_q[$];
  logic       link_taken = 1'b0;
  int         src_idle = 0;
  int         sink_stall = 0;
  bit         src_calm = 1'b0;
  bit         sink_calm = 1'b0;
  int         cycles = 0;
  int         errors = 0;
  int         n_xfer = 0;
  int         n_exec = 0;
  int         n_drop = 0;
  int         n_full = 0;
  int         n_skip = 0;
  int         n_hit = 0;
  logic [31:0] addr_pool [POOL_SIZE];

  // predictor state
  logic        hb_pending = 1'b0;
  logic [3:0]  hi_nib = '0;
  logic [3:0]  nbytes = '0;
  logic [7:0]  cmd_b = '0;
  logic [7:0]  len_b = '0;
  logic [31:0] addr_acc = '0;
  logic [1:0]  mode = MODE_RUN;
  logic [BP_ENTRIES-1:0] bp_valid = '0;
  logic [31:0] bp_addr [BP_ENTRIES];
  logic [31:0] skip_addr = '0;
  logic        skip_ok = 1'b0;

  hex_debug_command_breakpoint_unit_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic bp_hit(input logic [31:0] a);
    for (int i = 0; i < BP_ENTRIES; i++)
      if (bp_valid[i] && bp_addr[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  // returns 1 when the table had no room
  function automatic logic bp_insert(input logic [31:0] a);
    if (bp_hit(a)) return 1'b0;
    for (int i = 0; i < BP_ENTRIES; i++) begin
      if (!bp_valid[i]) begin
        bp_valid[i] = 1'b1;
        bp_addr[i] = a;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void bp_delete(input logic [31:0] a);
    for (int i = 0; i < BP_ENTRIES; i++)
      if (bp_valid[i] && bp_addr[i] == a) bp_valid[i] = 1'b0;
  endfunction

  function automatic void clear_msg();
    hb_pending = 1'b0;
    nbytes = '0;
    cmd_b = '0;
    len_b = '0;
    addr_acc = '0;
  endfunction

  function automatic result_t expected_response(input logic act, input logic [7:0] ch,
                                                input logic [31:0] pc);
    result_t     r;
    logic [3:0]  dig;
    logic        is_dig;
    logic [7:0]  b;
    logic [31:0] bp;
    r = '0;
    dig = '0;
    if (!act && mode != MODE_HALT) begin
      is_dig = 1'b1;
      if (ch >= CHAR_0 && ch <= CHAR_9) dig = 4'(ch - CHAR_0);
      else if (ch >= CHAR_A && ch <= CHAR_F) dig = 4'(ch - CHAR_A) + HEX_ALPHA_BASE;
      else is_dig = 1'b0;
      if (!is_dig) begin
        if (hb_pending) begin
          r.message_dropped = 1'b1;
          n_drop++;
          clear_msg();
        end else if (nbytes != 0) begin
          // address bytes that never came count as zeros
          bp = (len_b >= 8) ? '0 : addr_acc << (8 * len_b);
          r.command_done = 1'b1;
          r.command_code = cmd_b;
          n_exec++;
          case (cmd_b)
            CMD_RUN: begin
              if (mode == MODE_PAUSE && bp_hit(pc)) begin
                skip_addr = pc;
                skip_ok = 1'b1;
                n_skip++;
              end
              mode = MODE_RUN;
            end
            CMD_HALT:  mode = MODE_HALT;
            CMD_PAUSE: mode = MODE_PAUSE;
            CMD_STEP:  mode = MODE_STEP;
            CMD_BP_ADD: begin
              r.table_full = bp_insert(bp);
              if (r.table_full) n_full++;
            end
            CMD_BP_REMOVE: bp_delete(bp);
            CMD_DUMP, CMD_DUMP_LOCALS: mode = MODE_PAUSE;
            default: r.unknown_command = 1'b1;
          endcase
          clear_msg();
        end
      end else if (!hb_pending) begin
        hi_nib = dig;
        hb_pending = 1'b1;
      end else begin
        b = {hi_nib, dig};
        hb_pending = 1'b0;
        if (nbytes == 0) begin
          cmd_b = b;
          len_b = '0;
          addr_acc = '0;
        end else if (nbytes == 1) begin
          len_b = b;
        end else if (len_b != 0) begin
          addr_acc = {addr_acc[23:0], b};
          len_b = len_b - 1;
        end
        if (nbytes != BYTES_MAX) nbytes = nbytes + 1;
      end
    end
    r.run_mode = mode;
    r.hit = bp_hit(pc);
    r.skip_address = skip_addr;
    r.skip_valid = skip_ok;
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_A && c <= CHAR_F);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < HEX_ALPHA_BASE) ? CHAR_0 + 8'(n) : CHAR_A + 8'(n - HEX_ALPHA_BASE);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  function automatic logic [31:0] pick_pc();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put(input logic act, input logic [7:0] c, input logic [31:0] pc);
    link_item_t it;
    it = '{act, c, pc};
    link_q = {link_q, it};
  endtask

  task automatic put_byte(input logic [7:0] b);
    put(1'b0, hex_char(b[7:4]), pick_pc());
    put(1'b0, hex_char(b[3:0]), pick_pc());
  endtask

  task automatic cmd_msg(input logic [7:0] cmd, input logic [31:0] pc);
    put_byte(cmd);
    put(1'b0, non_hex(), pc);
  endtask

  // address bytes big-endian; bytes beyond the low four are random filler
  task automatic bp_msg(input logic [7:0] cmd, input logic [7:0] len,
                        input logic [31:0] a, input int nb);
    int k;
    put_byte(cmd);
    put_byte(len);
    for (int i = 0; i < nb; i++) begin
      k = nb - 1 - i;
      if (k < 4) put_byte(8'(a >> (8 * k)));
      else put_byte(8'($urandom_range(0, 255)));
    end
    put(1'b0, non_hex(), pick_pc());
  endtask

  task automatic random_traffic();
    int r;
    int len;
    int nb;
    logic [7:0] code;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
    if (r < 33) begin
      if ($urandom_range(0, 9) < 7) begin
        len = 4;
        nb = 4;
      end else if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(0, 5);
        nb = len + $urandom_range(0, 2) - 1;
        if (nb < 0) nb = 0;
      end else begin
        len = $urandom_range(0, 255);
        nb = $urandom_range(0, 6);
      end
      bp_msg(CMD_BP_ADD, 8'(len), a, nb);
    end else if (r < 48) begin
      bp_msg(CMD_BP_REMOVE, 8'd4, a, 4);
    end else if (r < 65) begin
      case ($urandom_range(0, 5))
        0, 1: code = CMD_RUN;
        2: code = CMD_PAUSE;
        3: code = CMD_STEP;
        4: code = CMD_DUMP;
        default: code = CMD_DUMP_LOCALS;
      endcase
      cmd_msg(code, pick_pc());
    end else if (r < 70) begin
      code = 8'($urandom_range(0, 255));
      if (code == CMD_HALT) code = CODE_SPARE_A;
      cmd_msg(code, pick_pc());
    end else if (r < 80) begin
      repeat ($urandom_range(1, 4)) put(1'b1, 8'($urandom_range(0, 255)), pick_pc());
    end else if (r < 88) begin
      // broken message: a lone digit then a terminator
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
      put(1'b0, hex_char(4'($urandom_range(0, 15))), pick_pc());
      put(1'b0, non_hex(), pick_pc());
    end else if (r < 94) begin
      repeat ($urandom_range(1, 3)) put(1'b0, 8'($urandom_range(0, 255)), $urandom);
    end else if (r < 97) begin
      // long message, byte count saturates
      bp_msg(CMD_BP_ADD, 8'($urandom_range(0, 255)), a, $urandom_range(13, 17));
    end else begin
      put(1'b0, non_hex(), pick_pc());
    end
  endtask

  task automatic report(input string name, input logic [31:0] e, input logic [31:0] g);
    if (e !== g) begin
      if (errors < 10)
        $display("mismatch on transfer %0d, %s: expected %h, got %h", n_xfer, name, e, g);
      errors++;
    end
  endtask

  // predictor runs on every accepted input transfer
  always @(posedge clk) begin
    link_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      response_q = {response_q, expected_response(s_tuser, s_tdata[7:0], s_tdata[39:8])};
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || link_taken) begin
      if (src_idle > 0) begin
        s_tvalid <= 1'b0;
        src_idle--;
      end else if (link_q.size() != 0) begin
        cur = link_q[0];
        link_q.delete(0);
        s_tuser <= cur.action;
        s_tdata <= {cur.pc, cur.ch};
        s_tvalid <= 1'b1;
        src_idle = idle_len(src_calm);
        if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall = idle_len(sink_calm);
      if ($urandom_range(0, 399) == 0) sink_calm = !sink_calm;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      n_xfer++;
      if (response_q.size() == 0) begin
        if (errors < 10) $display("unexpected result transfer: %h", m_tdata);
        errors++;
      end else begin
        exp = response_q[0];
        response_q.delete(0);
        if (exp.hit) n_hit++;
        report("command_done", exp.command_done, got.command_done);
        report("command_code", exp.command_code, got.command_code);
        report("run_mode", exp.run_mode, got.run_mode);
        report("hit", exp.hit, got.hit);
        report("skip_address", exp.skip_address, got.skip_address);
        report("skip_valid", exp.skip_valid, got.skip_valid);
        report("message_dropped", exp.message_dropped, got.message_dropped);
        report("table_full", exp.table_full, got.table_full);
        report("unknown_command", exp.unknown_command, got.unknown_command);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, response_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BP_ENTRIES; i++) bp_addr[i] = '0;
    addr_pool[0] = 32'hFFFF_FFFF;
    addr_pool[1] = 32'h0000_0000;
    addr_pool[2] = 32'h1234_0000;
    for (int i = 3; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    // directed messages
    put(1'b0, non_hex(), 32'h0);                       // empty message
    put(1'b1, CODE_ZERO, 32'h0);
    put(1'b1, CODE_ALL, 32'hFFFF_FFFF);
    bp_msg(CMD_BP_ADD, 8'd4, 32'hFFFF_FFFF, 4);
    put_byte(CMD_BP_ADD);                              // no length byte: adds zero
    put(1'b0, non_hex(), 32'h0);
    bp_msg(CMD_BP_ADD, 8'd4, 32'h0000_1234, 2);        // short address
    bp_msg(CMD_BP_ADD, 8'd6, 32'hA5C3_5A3C, 6);        // wide address
    bp_msg(CMD_BP_ADD, CODE_ALL, 32'h77, 1);           // oversized length
    bp_msg(CMD_BP_ADD, 8'd4, 32'hFFFF_FFFF, 4);        // duplicate
    bp_msg(CMD_BP_REMOVE, 8'd4, 32'hDEAD_BEEF, 4);     // not in table
    bp_msg(CMD_BP_REMOVE, 8'd2, 32'h0000_1234, 2);
    cmd_msg(CMD_PAUSE, 32'h0);
    cmd_msg(CMD_RUN, 32'hFFFF_FFFF);                   // resume on a breakpoint
    cmd_msg(CMD_STEP, 32'h0);
    cmd_msg(CMD_DUMP, 32'h0);
    cmd_msg(CMD_DUMP_LOCALS, 32'h0);
    cmd_msg(CODE_SPARE_A, 32'h0);
    cmd_msg(CODE_SPARE_B, 32'h0);
    cmd_msg(CODE_ALL, 32'h0);
    cmd_msg(CODE_ZERO, 32'h0);
    put(1'b0, CHAR_0, 32'h0);                          // dropped mid-byte
    put(1'b0, non_hex(), 32'h0);
    put_byte(CMD_PAUSE);                               // lower-case ends it
    put(1'b0, CHAR_LOWER_A, 32'hFFFF_FFFF);

    while (link_q.size() < LINK_ITEMS) random_traffic();

    // halt is final: the link is dead after it, queries still answer
    cmd_msg(CMD_HALT, pick_pc());
    repeat (40) put(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), pick_pc());

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (link_q.size() != 0 || s_tvalid) @(negedge clk);
    while (response_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d transfers checked: %0d commands executed, %0d messages dropped,",
             n_xfer, n_exec, n_drop);
    $display("%0d adds on a full table, %0d skip captures, %0d results with hit set",
             n_full, n_skip, n_hit);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hdcb_pkg.sv
hw/rtl/hdcb_fifo.sv
hw/rtl/hdcb_front.sv
hw/rtl/hdcb_back.sv
hw/rtl/hex_debug_command_breakpoint_unit_top.sv
tb/tb_top.sv
